@@ hdl/gmb_pkg.sv @@
// Package for the grid maze path marker: sizes, codes, controller states and
// the command/status structs. No dependencies.
package gmb_pkg;
    localparam int MaxRows = 64;
    localparam int MaxCols = 64;
    localparam int RowW = $clog2(MaxRows);
    localparam int ColW = $clog2(MaxCols);
    localparam int IdxW = RowW + ColW;
    localparam int Cells = MaxRows * MaxCols;
    localparam int CntW = IdxW + 1;

    typedef enum logic [1:0] {
        K_WRITE = 2'd0,
        K_SOLVE = 2'd1,
        K_READ  = 2'd2,
        K_NONE  = 2'd3
    } t_kind;

    localparam logic [2:0] CodeOpen  = 3'd0;
    localparam logic [2:0] CodeWall  = 3'd1;
    localparam logic [2:0] CodeStart = 3'd2;
    localparam logic [2:0] CodeDest  = 3'd3;
    localparam logic [2:0] CodePath  = 3'd4;

    localparam logic [1:0] DirRight = 2'd0;
    localparam logic [1:0] DirLeft  = 2'd1;
    localparam logic [1:0] DirUp    = 2'd2;
    localparam logic [1:0] DirDown  = 2'd3;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_POP,
        S_POP_WAIT,
        S_NB_RD,
        S_NB_CHK,
        S_WALK_RD,
        S_WALK_CHK,
        S_READ_WAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic clr_start;
        logic clr_step;
        logic solve_init;
        logic scan_rd;
        logic scan_next;
        logic bfs_seed;
        logic pop;
        logic pop_latch;
        logic nb_rd;
        logic nb_take;
        logic nb_next;
        logic walk_init;
        logic walk_rd;
        logic walk_step;
        logic cell_wr;
        logic cell_rd;
        logic out_load;
        logic out_zero;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic scan_start;
        logic scan_last;
        logic q_empty;
        logic nb_valid;
        logic nb_ok;
        logic nb_last;
        logic reached;
        logic walk_stop;
    } t_status;
endpackage

@@ hdl/gmb_stream_if.sv @@
// Valid/ready channel interface for the maze marker item and result beats.
// Depends on nothing.
interface gmb_stream_if #(
    parameter int W = 16
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hdl/grid_maze_bfs_path_marker.sv @@
// Top level of the grid maze BFS path marker: config registers, controller and
// datapath. Depends on gmb_pkg, gmb_stream_if, gmb_ctrl, gmb_datapath.
//
// channel  dir  beat payload
// i_item   in   kind[15:14] row[13:8] col[7:2] cell_code[1:0]
// o_res    out  cell_value[15:13] reached[12] path_length[11:0]
//
// Write and unused kinds go from idle straight to output; a read passes a wait state.
// Solve: clear visited over all 4096 cells, read and check each scanned cell, read
// the grid once per valid neighbor of a dequeued cell, read and step each path cell.
// After reset a pass clears all 4096 cells to open; items wait until it ends.
// One item in flight; a result waiting on o_res holds new items off.
module grid_maze_bfs_path_marker import gmb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gmb_stream_if.sink   i_item,
    gmb_stream_if.source o_res,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [6:0]  i_cfg_data
);
    logic [6:0] r_rows, r_cols;
    t_cmd       cmd;
    t_status    st;
    logic [2:0] cv;
    logic       rc;
    logic [11:0] pl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= 7'd64;
            r_cols <= 7'd64;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == 1'b0) r_rows <= i_cfg_data;
            else r_cols <= i_cfg_data;
        end
    end

    gmb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_kind      (t_kind'(i_item.data[15:14])),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_st        (st),
        .o_cmd       (cmd)
    );

    gmb_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_st          (st),
        .i_rows        (r_rows),
        .i_cols        (r_cols),
        .i_row         (i_item.data[13:8]),
        .i_col         (i_item.data[7:2]),
        .i_code        (i_item.data[1:0]),
        .o_cell_value  (cv),
        .o_reached     (rc),
        .o_path_length (pl)
    );

    assign o_res.data = {cv, rc, pl};

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.cell_wr && cmd.walk_step)) else $error("write during walk");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !i_item.ready) else $error("ready with result pending");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |=> o_res.valid) else $error("result dropped");
endmodule

@@ hdl/gmb_ctrl.sv @@
// Controller FSM for the maze marker: sequences clear, BFS, walk-back and IO.
// Depends on gmb_pkg.
module gmb_ctrl import gmb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_kind   i_kind,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_st,
    output t_cmd    o_cmd
);
    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;
    logic   take;

    assign o_in_ready  = (r_state == S_IDLE) && !r_ovalid;
    assign o_out_valid = r_ovalid;
    assign take        = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT:      if (i_st.clr_done) n_state = S_IDLE;
            S_IDLE: begin
                if (take) begin
                    unique case (i_kind)
                        K_SOLVE: n_state = S_CLEAR;
                        K_READ:  n_state = S_READ_WAIT;
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_CLEAR:     if (i_st.clr_done) n_state = S_SCAN_RD;
            S_SCAN_RD:   n_state = S_SCAN_CHK;
            S_SCAN_CHK: begin
                if (i_st.scan_start) n_state = S_POP;
                else if (i_st.scan_last) n_state = i_st.reached ? S_WALK_RD : S_OUT;
                else n_state = S_SCAN_RD;
            end
            S_POP: begin
                if (i_st.q_empty) begin
                    if (i_st.scan_last) n_state = i_st.reached ? S_WALK_RD : S_OUT;
                    else n_state = S_SCAN_RD;
                end else begin
                    n_state = S_POP_WAIT;
                end
            end
            S_POP_WAIT:  n_state = S_NB_RD;
            S_NB_RD:     n_state = i_st.nb_valid ? S_NB_CHK : (i_st.nb_last ? S_POP : S_NB_RD);
            S_NB_CHK:    n_state = i_st.nb_last ? S_POP : S_NB_RD;
            S_WALK_RD:   n_state = S_WALK_CHK;
            S_WALK_CHK:  n_state = i_st.walk_stop ? S_OUT : S_WALK_RD;
            S_READ_WAIT: n_state = S_OUT;
            S_OUT:       n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd    = '0;
        n_ovalid = r_ovalid && !i_out_ready;
        unique case (r_state)
            S_INIT:     o_cmd.clr_step = 1'b1;
            S_IDLE: begin
                if (take) begin
                    unique case (i_kind)
                        K_WRITE: o_cmd.cell_wr = 1'b1;
                        K_SOLVE: begin
                            o_cmd.clr_start  = 1'b1;
                            o_cmd.solve_init = 1'b1;
                        end
                        K_READ:  o_cmd.cell_rd = 1'b1;
                        default: ;
                    endcase
                    if (i_kind != K_READ) o_cmd.out_zero = 1'b1;
                end
            end
            S_CLEAR:    o_cmd.clr_step = 1'b1;
            S_SCAN_RD:  o_cmd.scan_rd = 1'b1;
            S_SCAN_CHK: begin
                if (i_st.scan_start) o_cmd.bfs_seed = 1'b1;
                else if (!i_st.scan_last) o_cmd.scan_next = 1'b1;
                else if (i_st.reached) o_cmd.walk_init = 1'b1;
            end
            S_POP: begin
                if (i_st.q_empty) begin
                    if (!i_st.scan_last) o_cmd.scan_next = 1'b1;
                    else if (i_st.reached) o_cmd.walk_init = 1'b1;
                end else begin
                    o_cmd.pop = 1'b1;
                end
            end
            S_POP_WAIT: o_cmd.pop_latch = 1'b1;
            S_NB_RD: begin
                o_cmd.nb_rd = i_st.nb_valid;
                if (!i_st.nb_valid) o_cmd.nb_next = 1'b1;
            end
            S_NB_CHK: begin
                o_cmd.nb_take = i_st.nb_ok;
                o_cmd.nb_next = 1'b1;
            end
            S_WALK_RD:   o_cmd.walk_rd = 1'b1;
            S_WALK_CHK:  o_cmd.walk_step = 1'b1;
            S_READ_WAIT: ;
            S_OUT: begin
                o_cmd.out_load = 1'b1;
                n_ovalid       = 1'b1;
            end
            default: ;
        endcase
    end
endmodule

@@ hdl/gmb_datapath.sv @@
// Datapath for the maze marker: grid, visited, parent and queue memories,
// scan/neighbor/walk address logic and the result register. Depends on gmb_pkg.
module gmb_datapath import gmb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_status          o_st,
    input  logic [6:0]       i_rows,
    input  logic [6:0]       i_cols,
    input  logic [RowW-1:0]  i_row,
    input  logic [ColW-1:0]  i_col,
    input  logic [1:0]       i_code,
    output logic [2:0]       o_cell_value,
    output logic             o_reached,
    output logic [11:0]      o_path_length
);
    logic [2:0]      grid_mem [Cells];
    logic            vis_mem  [Cells];
    logic [1:0]      par_mem  [Cells];
    logic [IdxW-1:0] q_mem    [Cells];

    logic [RowW:0]   nr, nc;
    logic [IdxW-1:0] r_clr, r_scan, r_cur, r_nb, r_walk, r_dest;
    logic [CntW-1:0] r_head, r_tail;
    logic [1:0]      r_dir;
    logic            r_clr_busy, r_reached;
    logic            r_gclr;
    logic [11:0]     r_marked;
    logic [2:0]      r_grid_q;
    logic            r_vis_q;
    logic [1:0]      r_par_q;
    logic [IdxW-1:0] r_q_q;
    logic [2:0]      r_val;

    logic [RowW-1:0] cr, wr_r;
    logic [ColW-1:0] cc, wr_c;
    logic            nb_valid;
    logic [IdxW-1:0] nb_idx, prev_idx;
    logic            prev_ok;

    always_comb begin
        nr = (i_rows == 7'd0) ? (RowW+1)'(1) :
             (i_rows > 7'(MaxRows)) ? (RowW+1)'(MaxRows) : i_rows[RowW:0];
        nc = (i_cols == 7'd0) ? (ColW+1)'(1) :
             (i_cols > 7'(MaxCols)) ? (ColW+1)'(MaxCols) : i_cols[ColW:0];
    end

    assign cr = r_cur[IdxW-1:ColW];
    assign cc = r_cur[ColW-1:0];
    always_comb begin
        nb_valid = 1'b0;
        nb_idx   = r_cur;
        unique case (r_dir)
            DirRight: begin
                nb_valid = ({1'b0, cc} + 1'b1) < nc;
                nb_idx   = {cr, cc + 1'b1};
            end
            DirLeft: begin
                nb_valid = cc != '0;
                nb_idx   = {cr, cc - 1'b1};
            end
            DirUp: begin
                nb_valid = cr != '0;
                nb_idx   = {cr - 1'b1, cc};
            end
            DirDown: begin
                nb_valid = ({1'b0, cr} + 1'b1) < nr;
                nb_idx   = {cr + 1'b1, cc};
            end
            default: ;
        endcase
    end

    assign wr_r = r_walk[IdxW-1:ColW];
    assign wr_c = r_walk[ColW-1:0];
    always_comb begin
        prev_ok  = 1'b0;
        prev_idx = r_walk;
        unique case (r_par_q)
            DirRight: begin
                prev_ok  = (wr_c != '0) && ({1'b0, wr_c} - 1'b1 < nc) && ({1'b0, wr_r} < nr);
                prev_idx = {wr_r, wr_c - 1'b1};
            end
            DirLeft: begin
                prev_ok  = ({1'b0, wr_c} + 1'b1 < nc) && ({1'b0, wr_r} < nr);
                prev_idx = {wr_r, wr_c + 1'b1};
            end
            DirUp: begin
                prev_ok  = ({1'b0, wr_r} + 1'b1 < nr) && ({1'b0, wr_c} < nc);
                prev_idx = {wr_r + 1'b1, wr_c};
            end
            DirDown: begin
                prev_ok  = (wr_r != '0) && ({1'b0, wr_r} - 1'b1 < nr) && ({1'b0, wr_c} < nc);
                prev_idx = {wr_r - 1'b1, wr_c};
            end
            default: ;
        endcase
    end

    // grid memory: one port, address muxed by phase
    logic [IdxW-1:0] g_addr;
    logic            g_we;
    logic [2:0]      g_wd;
    always_comb begin
        g_addr = {i_row, i_col};
        g_we   = 1'b0;
        g_wd   = {1'b0, i_code};
        if (r_gclr) begin
            g_addr = r_clr;
            g_we   = 1'b1;
            g_wd   = CodeOpen;
        end else if (i_cmd.cell_wr) g_we = 1'b1;
        else if (i_cmd.scan_rd) g_addr = r_scan;
        else if (i_cmd.nb_rd) g_addr = nb_idx;
        else if (i_cmd.walk_rd) g_addr = r_walk;
        else if (i_cmd.walk_step && r_grid_q != CodeStart && r_grid_q != CodeDest) begin
            g_addr = r_walk;
            g_we   = 1'b1;
            g_wd   = CodePath;
        end
    end
    always_ff @(posedge i_clk) begin
        if (g_we) grid_mem[g_addr] <= g_wd;
        r_grid_q <= grid_mem[g_addr];
    end

    logic [IdxW-1:0] v_addr;
    logic            v_we, v_wd;
    always_comb begin
        v_addr = nb_idx;
        v_we   = 1'b0;
        v_wd   = 1'b1;
        if (r_clr_busy) begin
            v_addr = r_clr;
            v_we   = 1'b1;
            v_wd   = 1'b0;
        end else if (i_cmd.bfs_seed) begin
            v_addr = r_scan;
            v_we   = 1'b1;
        end else if (i_cmd.nb_take) begin
            v_addr = r_nb;
            v_we   = 1'b1;
        end else if (i_cmd.scan_rd) begin
            v_addr = r_scan;
        end
    end
    always_ff @(posedge i_clk) begin
        if (v_we) vis_mem[v_addr] <= v_wd;
        r_vis_q <= vis_mem[v_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.nb_take) par_mem[r_nb] <= r_dir;
        r_par_q <= par_mem[r_walk];
    end

    logic [IdxW-1:0] q_wa, q_wd;
    logic            q_we;
    always_comb begin
        q_we = i_cmd.bfs_seed || i_cmd.nb_take;
        q_wa = i_cmd.bfs_seed ? IdxW'(0) : r_tail[IdxW-1:0];
        q_wd = i_cmd.bfs_seed ? r_scan : r_nb;
    end
    always_ff @(posedge i_clk) begin
        if (q_we) q_mem[q_wa] <= q_wd;
        r_q_q <= q_mem[r_head[IdxW-1:0]];
    end

    // scan-start check: grid code must be start (visited ignored by model)
    assign o_st.clr_done   = !r_clr_busy && !i_cmd.clr_start;
    assign o_st.scan_start = (r_grid_q == CodeStart);
    assign o_st.scan_last  = ({1'b0, r_scan[ColW-1:0]} + 1'b1 >= nc) &&
                             ({1'b0, r_scan[IdxW-1:ColW]} + 1'b1 >= nr);
    assign o_st.q_empty    = r_head >= r_tail;
    assign o_st.nb_valid   = nb_valid;
    assign o_st.nb_ok      = !r_vis_q && (r_grid_q != CodeWall) && (r_tail < CntW'(Cells));
    assign o_st.nb_last    = r_dir == DirDown;
    assign o_st.reached    = r_reached;
    assign o_st.walk_stop  = (r_grid_q == CodeStart) || !prev_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_gclr     <= 1'b1;
            r_clr      <= '0;
            r_reached  <= 1'b0;
            r_marked   <= '0;
            r_dest     <= '0;
        end else begin
            if (i_cmd.clr_start) begin
                r_clr_busy <= 1'b1;
                r_clr      <= '0;
            end else if (r_clr_busy && i_cmd.clr_step) begin
                r_clr <= r_clr + 1'b1;
                if (r_clr == IdxW'(Cells - 1)) begin
                    r_clr_busy <= 1'b0;
                    r_gclr     <= 1'b0;
                end
            end
            if (i_cmd.solve_init) begin
                r_reached <= 1'b0;
                r_marked  <= '0;
                r_dest    <= '0;
                r_scan    <= '0;
            end
            if (i_cmd.scan_next) begin
                if ({1'b0, r_scan[ColW-1:0]} + 1'b1 >= nc)
                    r_scan <= {r_scan[IdxW-1:ColW] + 1'b1, {ColW{1'b0}}};
                else
                    r_scan <= r_scan + 1'b1;
            end
            if (i_cmd.bfs_seed) begin
                r_head <= '0;
                r_tail <= CntW'(1);
            end
            if (i_cmd.pop) r_head <= r_head + 1'b1;
            if (i_cmd.pop_latch) begin
                r_cur <= r_q_q;
                r_dir <= DirRight;
            end
            if (i_cmd.nb_rd) r_nb <= nb_idx;
            if (i_cmd.nb_next) r_dir <= r_dir + 1'b1;
            if (i_cmd.nb_take) begin
                r_tail <= r_tail + 1'b1;
                if (r_grid_q == CodeDest) begin
                    r_dest    <= r_nb;
                    r_reached <= 1'b1;
                end
            end
            if (i_cmd.walk_init) r_walk <= r_dest;
            if (i_cmd.walk_step) begin
                if (r_grid_q != CodeStart && r_grid_q != CodeDest && r_marked != 12'hFFF)
                    r_marked <= r_marked + 1'b1;
                r_walk <= prev_idx;
            end
        end
    end

    // walk: read grid and parent of r_walk; par read is unconditional on r_walk
    logic r_rd_pend;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_rd_pend <= 1'b0;
        else r_rd_pend <= i_cmd.cell_rd;
        if (i_cmd.out_zero) r_val <= CodeOpen;
        else if (r_rd_pend) r_val <= r_grid_q;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_cell_value  <= r_val;
            o_reached     <= r_reached;
            o_path_length <= r_marked;
        end
    end
endmodule

@@ dv/gmb_maze_checker.sv @@
// Checker for the grid maze path marker: watches the item, result and register
// channels, predicts every result beat and compares it field by field.
// Depends on gmb_pkg and gmb_stream_if.
module gmb_maze_checker import gmb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gmb_stream_if       item_ch,
    gmb_stream_if       res_ch,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [6:0]  i_cfg_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_solves,
    output int          o_reached
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]  cell_value;
        logic        reached;
        logic [11:0] path_length;
    } t_status_beat;

    logic [2:0]  maze_grid [Cells];
    logic        seen [Cells];
    logic [1:0]  came_from [Cells];
    int          frontier [Cells];
    logic [6:0]  rows_reg, cols_reg;
    logic        dest_hit;
    int          dest_cell;
    int          marked;
    t_status_beat status_q [$];

    function automatic int clamp_dim(logic [6:0] v, int hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int step_row(logic [1:0] d);
        return (d == DirUp) ? -1 : (d == DirDown) ? 1 : 0;
    endfunction

    function automatic int step_col(logic [1:0] d);
        return (d == DirRight) ? 1 : (d == DirLeft) ? -1 : 0;
    endfunction

    task automatic flood_from(int origin, int nr, int nc);
        int head, tail, p, r, c, idx;
        logic [1:0] d;
        head = 0;
        tail = 0;
        frontier[tail++] = origin;
        seen[origin] = 1'b1;
        while (head < tail) begin
            p = frontier[head++];
            for (int k = 0; k < 4; k++) begin
                d = k[1:0];
                r = p / MaxCols + step_row(d);
                c = p % MaxCols + step_col(d);
                if (r < 0 || r >= nr || c < 0 || c >= nc) continue;
                idx = r * MaxCols + c;
                if (seen[idx] || maze_grid[idx] == CodeWall) continue;
                if (tail >= Cells) continue;
                frontier[tail++] = idx;
                seen[idx] = 1'b1;
                came_from[idx] = d;
                if (maze_grid[idx] == CodeDest) begin
                    dest_cell = idx;
                    dest_hit = 1'b1;
                end
            end
        end
    endtask

    task automatic solve_maze();
        int nr, nc, cur, pr, pc;
        logic [1:0] d;
        nr = clamp_dim(rows_reg, MaxRows);
        nc = clamp_dim(cols_reg, MaxCols);
        foreach (seen[i]) seen[i] = 1'b0;
        dest_hit = 1'b0;
        dest_cell = 0;
        marked = 0;
        for (int r = 0; r < nr; r++)
            for (int c = 0; c < nc; c++)
                if (maze_grid[r * MaxCols + c] == CodeStart) flood_from(r * MaxCols + c, nr, nc);
        o_solves++;
        if (!dest_hit) return;
        o_reached++;
        cur = dest_cell;
        for (int g = 0; g < Cells && maze_grid[cur] != CodeStart; g++) begin
            d = came_from[cur];
            if (maze_grid[cur] != CodeDest) begin
                maze_grid[cur] = CodePath;
                if (marked < 4095) marked++;
            end
            pr = cur / MaxCols - step_row(d);
            pc = cur % MaxCols - step_col(d);
            if (pr < 0 || pr >= nr || pc < 0 || pc >= nc) break;
            cur = pr * MaxCols + pc;
        end
    endtask

    initial begin
        foreach (maze_grid[i]) maze_grid[i] = CodeOpen;
        foreach (came_from[i]) came_from[i] = DirRight;
        rows_reg = 7'd64;
        cols_reg = 7'd64;
        dest_hit = 1'b0;
        dest_cell = 0;
        marked = 0;
        o_errors = 0;
        o_pending = 0;
        o_solves = 0;
        o_reached = 0;
    end

    always @(posedge i_clk) begin
        t_kind        kind;
        int           idx;
        t_status_beat exp_beat, got;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                if (i_cfg_idx == 1'b0) rows_reg = i_cfg_data;
                else cols_reg = i_cfg_data;
            end
            if (item_ch.valid && item_ch.ready) begin
                kind = t_kind'(item_ch.data[15:14]);
                idx = item_ch.data[13:8] * MaxCols + item_ch.data[7:2];
                exp_beat.cell_value = CodeOpen;
                case (kind)
                    K_WRITE: maze_grid[idx] = {1'b0, item_ch.data[1:0]};
                    K_SOLVE: solve_maze();
                    K_READ:  exp_beat.cell_value = maze_grid[idx];
                    default: ;
                endcase
                exp_beat.reached = dest_hit;
                exp_beat.path_length = marked[11:0];
                status_q.push_back(exp_beat);
            end
            if (res_ch.valid && res_ch.ready) begin
                got = res_ch.data;
                if (status_q.size() == 0) begin
                    $display("%0t: unexpected result beat %h", $time, got);
                    o_errors++;
                end else begin
                    exp_beat = status_q.pop_front();
                    if (got.cell_value !== exp_beat.cell_value) begin
                        $display("%0t: cell_value exp %0d got %0d", $time,
                                 exp_beat.cell_value, got.cell_value);
                        o_errors++;
                    end
                    if (got.reached !== exp_beat.reached) begin
                        $display("%0t: reached exp %0d got %0d", $time,
                                 exp_beat.reached, got.reached);
                        o_errors++;
                    end
                    if (got.path_length !== exp_beat.path_length) begin
                        $display("%0t: path_length exp %0d got %0d", $time,
                                 exp_beat.path_length, got.path_length);
                        o_errors++;
                    end
                end
            end
        end
        o_pending = status_q.size();
    end
endmodule

@@ dv/tb.sv @@
// Testbench top for the grid maze path marker: clock, reset, item and register
// stimulus, result back-pressure, watchdog and verdict.
// Depends on gmb_pkg, gmb_stream_if, gmb_maze_checker and the block.
module tb;
    import gmb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IdleLimit = 400000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_idx = 1'b0;
    logic [6:0] i_cfg_data = '0;
    int         errors, pending, solves, reached_cnt;
    int         items_sent = 0;
    int         idle_cycles = 0;
    bit         no_gaps = 1'b0;

    gmb_stream_if #(.W(16)) item_ch ();
    gmb_stream_if #(.W(16)) res_ch ();

    always #5 i_clk = ~i_clk;

    grid_maze_bfs_path_marker dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(item_ch), .o_res(res_ch),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    gmb_maze_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .item_ch(item_ch), .res_ch(res_ch),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending), .o_solves(solves),
        .o_reached(reached_cnt)
    );

    initial begin
        item_ch.valid = 1'b0;
        item_ch.data = '0;
        res_ch.ready = 1'b0;
    end

    // result back-pressure
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            n = no_gaps ? 0 : $urandom_range(0, 10);
            if (n > 0) begin
                res_ch.ready <= 1'b0;
                repeat (n) @(negedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_ch.valid && res_ch.ready));
        end
    end

    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // called right after a negedge or an accepting posedge's following negedge
    task automatic send(t_kind kind, int row, int col, int code);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data <= {kind, row[5:0], col[5:0], code[1:0]};
        do @(posedge i_clk); while (!item_ch.ready);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic drain();
        item_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_dims(int nr, int nc);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= 1'b0;
        i_cfg_data <= nr[6:0];
        @(negedge i_clk);
        i_cfg_idx <= 1'b1;
        i_cfg_data <= nc[6:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic int pick_code();
        int w;
        w = $urandom_range(0, 99);
        if (w < 50) return CodeOpen;
        if (w < 78) return CodeWall;
        if (w < 88) return CodeStart;
        return CodeDest;
    endfunction

    task automatic maze_phase(int nr, int nc, int count);
        int er, ec, w;
        er = (nr < 1) ? 1 : (nr > 64) ? 64 : nr;
        ec = (nc < 1) ? 1 : (nc > 64) ? 64 : nc;
        set_dims(nr, nc);
        no_gaps = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < count; i++) begin
            w = $urandom_range(0, 99);
            if (w < 66)
                send(K_WRITE, $urandom_range(0, er - 1), $urandom_range(0, ec - 1), pick_code());
            else if (w < 78)
                send(K_READ, $urandom_range(0, er - 1), $urandom_range(0, ec - 1), $urandom);
            else if (w < 84)
                send(K_SOLVE, $urandom, $urandom, $urandom);
            else if (w < 90)
                send(K_WRITE, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
            else if (w < 96)
                send(K_READ, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
            else
                send(K_NONE, $urandom, $urandom, $urandom);
        end
        send(K_SOLVE, 0, 0, 0);
        for (int i = 0; i < 12; i++)
            send(K_READ, $urandom_range(0, er - 1), $urandom_range(0, ec - 1), 0);
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: default 64x64 area, corner destination, stale path marks
        send(K_READ, 0, 0, 0);
        send(K_WRITE, 0, 0, CodeDest);
        send(K_WRITE, 0, 2, CodeStart);
        send(K_SOLVE, 0, 0, 0);
        send(K_READ, 0, 1, 0);
        send(K_READ, 0, 0, 0);
        send(K_NONE, 63, 63, 3);
        send(K_WRITE, 63, 63, CodeDest);
        send(K_WRITE, 63, 62, CodeWall);
        send(K_WRITE, 62, 63, CodeWall);
        drain();
        send(K_SOLVE, 0, 0, 0);
        send(K_WRITE, 0, 1, CodeStart);
        send(K_SOLVE, 0, 0, 0);
        send(K_READ, 63, 63, 0);
        send(K_WRITE, 63, 62, CodeOpen);
        send(K_SOLVE, 0, 0, 0);
        send(K_READ, 63, 62, 0);
        send(K_WRITE, 0, 0, CodeOpen);
        send(K_SOLVE, 0, 0, 0);

        maze_phase(0, 0, 30);
        maze_phase(127, 127, 40);
        maze_phase(1, 64, 60);
        maze_phase(64, 1, 60);
        maze_phase(2, 2, 60);
        maze_phase(4, 4, 80);
        maze_phase(6, 9, 100);
        maze_phase(8, 5, 100);
        maze_phase(3, 12, 100);
        for (int p = 0; p < 4; p++)
            maze_phase($urandom_range(1, 12), $urandom_range(1, 12), 70);
        maze_phase(64, 64, 30);

        drain();
        $display("Covered %0d items over several grid sizes: %0d solves, %0d reached a target.",
                 items_sent, solves, reached_cnt);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
